[src/bdsr_pkg.sv]
`timescale 1ns / 1ps

package bdsr_pkg;

  localparam int unsigned MAX_RADIUS_DEF  = 16;
  localparam int unsigned LINE_WIDTH_DEF  = 320;
  localparam int unsigned BAND_HEIGHT_DEF = 16;

  localparam int unsigned COORD_W     = 12;
  localparam int unsigned RAD_IN_W    = 8;
  localparam int unsigned COLOR_W     = 16;
  localparam int unsigned BAND_ROW_W  = 4;
  localparam int unsigned COL_W       = 9;
  localparam int unsigned FIRST_ROW_W = 11;
  localparam int unsigned ROW_CNT_W   = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // working width for signed screen positions and offsets
  localparam int unsigned POS_W = 14;

  // half-width table covers every legal MAX_RADIUS; only r >= |dy| is kept
  localparam int unsigned HW_R_LIMIT = 20;
  localparam int unsigned HW_R_W     = $clog2(HW_R_LIMIT + 1);
  localparam int unsigned DY_W       = HW_R_W + 1;
  localparam int unsigned HW_W       = 5;
  localparam int unsigned HW_ENTRIES = (HW_R_LIMIT + 1) * (HW_R_LIMIT + 2) / 2;
  localparam int unsigned HW_IDX_W   = $clog2(HW_ENTRIES);

  localparam int unsigned MAX_RESULTS = 50;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_FIRST_ROW = 2'd0,
    REG_BAND_ROW_COUNT = 2'd1,
    REG_HIGHLIGHT_ON   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic [RAD_IN_W-1:0]       radius;
    logic [COLOR_W-1:0]        fill_color;
    logic [COLOR_W-1:0]        highlight_color;
  } in_item_t;

  typedef struct packed {
    logic [BAND_ROW_W-1:0] band_row;
    logic [COL_W-1:0]      span_start;
    logic [COL_W-1:0]      span_end;
    logic [COLOR_W-1:0]    span_color;
    logic                  last_span;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic [FIRST_ROW_W-1:0] band_first_row;
    logic [ROW_CNT_W-1:0]   band_row_count;
    logic                   highlight_on;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic [HW_R_W-1:0]       r;
    logic [COLOR_W-1:0]      color;
  } disc_t;

  typedef struct packed {
    disc_t main_disc;
    disc_t hl_disc;
    logic  has_hl;
  } job_t;

  typedef logic [HW_W-1:0] hw_table_t [HW_ENTRIES];

  // entry r*(r+1)/2 + |dy| holds round(sqrt(r*r - dy*dy))
  function automatic hw_table_t build_hw_table();
    hw_table_t   t;
    int unsigned idx;
    int unsigned n;
    int unsigned w;
    idx = 0;
    for (int unsigned r = 0; r <= HW_R_LIMIT; r++) begin
      for (int unsigned a = 0; a <= r; a++) begin
        n = r * r - a * a;
        w = 0;
        for (int unsigned k = 1; k <= HW_R_LIMIT; k++) begin
          if (k * k <= n) begin
            w = k;
          end
        end
        if (n > w * w + w) begin
          w = w + 1;
        end
        t[idx] = HW_W'(w);
        idx = idx + 1;
      end
    end
    return t;
  endfunction

  localparam hw_table_t HW_TABLE = build_hw_table();

endpackage

[src/bdsr_chan_if.sv]
`timescale 1ns / 1ps

interface bdsr_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/band_disc_span_rasterizer_core.sv]
`timescale 1ns / 1ps

// Channel  Dir  Payload      Accept
// in_i     in   in_item_t    in_i.valid & in_i.ready
// out_o    out  out_item_t   out_o.valid & out_o.ready
// cfg_i    in   cfg_item_t   cfg_i.valid & cfg_i.ready (ready tied high)
//
// For each disc drawn the back end takes a setup step, then walks the band rows the disc
// covers (at most BAND_HEIGHT), one row per cycle unless an output stall holds it; a
// disc that misses the band takes only the setup step, and each item also passes
// through the idle and flush steps.
// A 2-deep job queue lets the front take new items while the back end works.
// Output stalls hold the row walker only when a new span needs the output slot.
// Reset clears all control state; config resets to row 0, 16 rows, highlight on.

module band_disc_span_rasterizer_core #(
  parameter int unsigned MAX_RADIUS  = bdsr_pkg::MAX_RADIUS_DEF,
  parameter int unsigned LINE_WIDTH  = bdsr_pkg::LINE_WIDTH_DEF,
  parameter int unsigned BAND_HEIGHT = bdsr_pkg::BAND_HEIGHT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bdsr_chan_if.sink    in_i,
  bdsr_chan_if.source  out_o,
  bdsr_chan_if.sink    cfg_i
);
  import bdsr_pkg::*;

  cfg_t cfg_q, cfg_d;
  job_t push_job;
  job_t head_job;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.data.index))
        REG_BAND_FIRST_ROW: cfg_d.band_first_row = cfg_i.data.wdata[FIRST_ROW_W-1:0];
        REG_BAND_ROW_COUNT: cfg_d.band_row_count = cfg_i.data.wdata[ROW_CNT_W-1:0];
        REG_HIGHLIGHT_ON:   cfg_d.highlight_on   = cfg_i.data.wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.band_first_row <= '0;
      cfg_q.band_row_count <= ROW_CNT_W'(16);
      cfg_q.highlight_on   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bdsr_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .in_i   (in_i),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  bdsr_fifo #(
    .T     (job_t),
    .DEPTH (2)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head_job)
  );

  bdsr_back #(
    .LINE_WIDTH  (LINE_WIDTH),
    .BAND_HEIGHT (BAND_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

[src/bdsr_fifo.sv]
`timescale 1ns / 1ps

module bdsr_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output T     rdata_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  T                  mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == FILL_W'(DEPTH));
  assign valid_o = (fill_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> !full_o)
    else $error("fifo overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("fifo underflow");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(DEPTH))
    else $error("fifo fill count out of range");

endmodule

[src/bdsr_front.sv]
`timescale 1ns / 1ps

module bdsr_front #(
  parameter int unsigned MAX_RADIUS = bdsr_pkg::MAX_RADIUS_DEF
) (
  bdsr_chan_if.sink       in_i,
  input  bdsr_pkg::cfg_t  cfg_i,
  input  logic            full_i,
  output logic            push_o,
  output bdsr_pkg::job_t  job_o
);
  import bdsr_pkg::*;

  logic [HW_R_W-1:0]       r;
  logic [HW_R_W-1:0]       r_third;
  logic [HW_R_W-1:0]       r_half;
  logic [HW_R_W+3:0]       third_prod;
  logic signed [POS_W-1:0] cx;
  logic signed [POS_W-1:0] cy;
  logic signed [POS_W-1:0] shift;

  always_comb begin
    if (in_i.data.radius == '0) begin
      r = HW_R_W'(1);
    end else if (in_i.data.radius > RAD_IN_W'(MAX_RADIUS)) begin
      r = HW_R_W'(MAX_RADIUS);
    end else begin
      r = in_i.data.radius[HW_R_W-1:0];
    end
  end

  // r/3 as r*11 >> 5, exact for r up to the table limit
  assign third_prod = (HW_R_W + 4)'(r) * (HW_R_W + 4)'(11);
  assign r_third    = HW_R_W'(third_prod >> 5);
  assign r_half     = r >> 1;

  assign cx    = {{(POS_W - COORD_W){in_i.data.center_x[COORD_W-1]}}, in_i.data.center_x};
  assign cy    = {{(POS_W - COORD_W){in_i.data.center_y[COORD_W-1]}}, in_i.data.center_y};
  assign shift = POS_W'(r_third);

  assign job_o.main_disc.cx    = cx;
  assign job_o.main_disc.cy    = cy;
  assign job_o.main_disc.r     = r;
  assign job_o.main_disc.color = in_i.data.fill_color;
  assign job_o.hl_disc.cx      = cx - shift;
  assign job_o.hl_disc.cy      = cy - shift;
  assign job_o.hl_disc.r       = r_half;
  assign job_o.hl_disc.color   = in_i.data.highlight_color;
  assign job_o.has_hl          = cfg_i.highlight_on && (r >= HW_R_W'(3));

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

endmodule

[src/bdsr_back.sv]
`timescale 1ns / 1ps

module bdsr_back #(
  parameter int unsigned LINE_WIDTH  = bdsr_pkg::LINE_WIDTH_DEF,
  parameter int unsigned BAND_HEIGHT = bdsr_pkg::BAND_HEIGHT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bdsr_pkg::cfg_t  cfg_i,
  input  logic            job_valid_i,
  input  bdsr_pkg::job_t  job_i,
  output logic            pop_o,
  bdsr_chan_if.source     out_o
);
  import bdsr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_ROW   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  localparam logic signed [POS_W-1:0] BandH = POS_W'(BAND_HEIGHT);
  localparam logic signed [POS_W-1:0] LineW = POS_W'(LINE_WIDTH);

  state_e                  state_q, state_d;
  logic                    disc_q, disc_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic signed [DY_W-1:0]  dy_q, dy_d;
  logic signed [DY_W-1:0]  dy_end_q, dy_end_d;
  logic signed [POS_W-1:0] cx_q, cx_d;
  logic signed [POS_W-1:0] rowb_q, rowb_d;
  logic [HW_IDX_W-1:0]     base_q, base_d;
  logic [COLOR_W-1:0]      color_q, color_d;
  logic                    pend_valid_q, pend_valid_d;
  out_item_t               pend_q, pend_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q, out_d;

  // disc setup
  disc_t                   disc;
  logic signed [POS_W-1:0] y0, rows, r_s, lo, hi, dy0, dy1;
  logic [2*HW_R_W-1:0]     tri_prod;
  logic                    disc_empty;
  logic                    more_disc;

  // row evaluation
  logic [HW_R_W-1:0]       ady;
  logic [HW_IDX_W-1:0]     idx;
  logic signed [POS_W-1:0] hw_s, dy_ext, x0, x1, brow;
  logic                    hit;
  logic                    out_free;
  out_item_t               span;

  assign disc      = disc_q ? job_i.hl_disc : job_i.main_disc;
  assign more_disc = !disc_q && job_i.has_hl;

  always_comb begin
    y0 = POS_W'(cfg_i.band_first_row);
    rows = POS_W'(cfg_i.band_row_count);
    if (rows > BandH) begin
      rows = BandH;
    end
    r_s = POS_W'(disc.r);
    lo  = y0 - disc.cy;
    hi  = y0 + rows - POS_W'(1) - disc.cy;
    dy0 = (lo > -r_s) ? lo : -r_s;
    dy1 = (hi < r_s) ? hi : r_s;
    disc_empty = (rows == '0) || (dy0 > dy1);
  end

  assign tri_prod = (2 * HW_R_W)'(disc.r) * ((2 * HW_R_W)'(disc.r) + (2 * HW_R_W)'(1));

  always_comb begin
    ady    = dy_q[DY_W-1] ? HW_R_W'(-dy_q) : HW_R_W'(dy_q);
    idx    = base_q + HW_IDX_W'(ady);
    hw_s   = POS_W'(HW_TABLE[idx]);
    dy_ext = POS_W'(dy_q);
    x0     = cx_q - hw_s;
    x1     = cx_q + hw_s;
    if (x0 < 0) begin
      x0 = '0;
    end
    if (x1 >= LineW) begin
      x1 = LineW - POS_W'(1);
    end
    brow = rowb_q + dy_ext;
    hit  = !(x0 > x1) && (count_q < CNT_W'(MAX_RESULTS));
    span.band_row   = brow[BAND_ROW_W-1:0];
    span.span_start = x0[COL_W-1:0];
    span.span_end   = x1[COL_W-1:0];
    span.span_color = color_q;
    span.last_span  = 1'b0;
  end

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d      = state_q;
    disc_d       = disc_q;
    count_d      = count_q;
    dy_d         = dy_q;
    dy_end_d     = dy_end_q;
    cx_d         = cx_q;
    rowb_d       = rowb_q;
    base_d       = base_q;
    color_d      = color_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_d        = out_q;
    pop_o        = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (job_valid_i) begin
          disc_d  = 1'b0;
          count_d = '0;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        if (disc_empty) begin
          if (more_disc) begin
            disc_d = 1'b1;
          end else begin
            state_d = S_FLUSH;
          end
        end else begin
          dy_d     = DY_W'(dy0);
          dy_end_d = DY_W'(dy1);
          cx_d     = disc.cx;
          rowb_d   = disc.cy - y0;
          base_d   = HW_IDX_W'(tri_prod >> 1);
          color_d  = disc.color;
          state_d  = S_ROW;
        end
      end
      S_ROW: begin
        if (!(hit && pend_valid_q && !out_free)) begin
          if (hit) begin
            if (pend_valid_q) begin
              out_d       = pend_q;
              out_valid_d = 1'b1;
            end
            pend_d       = span;
            pend_valid_d = 1'b1;
            count_d      = count_q + CNT_W'(1);
          end
          if (dy_q == dy_end_q) begin
            if (more_disc) begin
              disc_d  = 1'b1;
              state_d = S_SETUP;
            end else begin
              state_d = S_FLUSH;
            end
          end else begin
            dy_d = dy_q + DY_W'(1);
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          pop_o   = 1'b1;
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d           = pend_q;
          out_d.last_span = 1'b1;
          out_valid_d     = 1'b1;
          pend_valid_d    = 1'b0;
          pop_o           = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      disc_q       <= 1'b0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      disc_q       <= disc_d;
      count_q      <= count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dy_q     <= dy_d;
    dy_end_q <= dy_end_d;
    cx_q     <= cx_d;
    rowb_q   <= rowb_d;
    base_q   <= base_d;
    color_q  <= color_d;
    pend_q   <= pend_d;
    out_q    <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_RESULTS))
    else $error("span count above cap");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROW) |-> (dy_q <= dy_end_q))
    else $error("row walk past disc end");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("pending span left over between items");

  a_pop_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (job_valid_i && (state_q == S_FLUSH)))
    else $error("job popped outside flush");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import bdsr_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int MAX_R         = MAX_RADIUS_DEF;
  localparam int BAND_LINES    = BAND_HEIGHT_DEF;
  localparam int LINE_COLS     = LINE_WIDTH_DEF;
  localparam int SETTLE_CYCLES = 200;
  localparam int STALL_LIMIT   = 2000;
  localparam int IDLE_PCT      = 36;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk_i;
  logic rst_ni;

  bdsr_chan_if #(.T(in_item_t))  in_if ();
  bdsr_chan_if #(.T(out_item_t)) out_if ();
  bdsr_chan_if #(.T(cfg_item_t)) cfg_if ();

  band_disc_span_rasterizer_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  cfg_t      band_cfg;
  out_item_t pending_spans[$];
  logic [HW_W-1:0] half_width [MAX_R+1][2*MAX_R+1];
  int idle_pct;
  int discs_sent;
  int spans_checked;
  int reg_writes;
  int error_count;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // rounded half-width of every disc row
  function automatic int round_root(int n);
    int w;
    w = 0;
    while ((w + 1) * (w + 1) <= n) w++;
    if (n > w * w + w) w++;
    return w;
  endfunction

  initial begin
    for (int r = 0; r <= MAX_R; r++) begin
      for (int d = 0; d <= 2 * MAX_R; d++) begin
        half_width[r][d] = '0;
      end
      for (int dy = -r; dy <= r; dy++) begin
        half_width[r][dy + r] = HW_W'(round_root(r * r - dy * dy));
      end
    end
  end

  function automatic void add_disc_spans(ref out_item_t spans[$], input int cx,
                                         input int cy, input int r,
                                         input logic [COLOR_W-1:0] color);
    int y0;
    int rows;
    int dy_lo;
    int dy_hi;
    int hw;
    int x0;
    int x1;
    out_item_t s;
    y0 = band_cfg.band_first_row;
    rows = band_cfg.band_row_count;
    if (rows > BAND_LINES) rows = BAND_LINES;
    if (rows < 1) return;
    dy_lo = -r;
    dy_hi = r;
    if (cy + dy_lo < y0) dy_lo = y0 - cy;
    if (cy + dy_hi >= y0 + rows) dy_hi = y0 + rows - 1 - cy;
    for (int dy = dy_lo; dy <= dy_hi; dy++) begin
      hw = half_width[r][dy + r];
      x0 = cx - hw;
      x1 = cx + hw;
      if (x0 < 0) x0 = 0;
      if (x1 >= LINE_COLS) x1 = LINE_COLS - 1;
      if (x0 <= x1) begin
        if (spans.size() >= MAX_RESULTS) return;
        s.band_row   = BAND_ROW_W'(cy + dy - y0);
        s.span_start = COL_W'(x0);
        s.span_end   = COL_W'(x1);
        s.span_color = color;
        s.last_span  = 1'b0;
        spans.push_back(s);
      end
    end
  endfunction

  function automatic void predict_spans(in_item_t it);
    out_item_t spans[$];
    int cx;
    int cy;
    int r;
    cx = int'($signed(it.center_x));
    cy = int'($signed(it.center_y));
    r  = int'(it.radius);
    if (r < 1) r = 1;
    if (r > MAX_R) r = MAX_R;
    add_disc_spans(spans, cx, cy, r, it.fill_color);
    if (band_cfg.highlight_on && r >= 3) begin
      add_disc_spans(spans, cx - r / 3, cy - r / 3, r / 2, it.highlight_color);
    end
    if (spans.size() > 0) spans[spans.size() - 1].last_span = 1'b1;
    foreach (spans[i]) pending_spans.push_back(spans[i]);
  endfunction

  function automatic in_item_t make_disc(int cx, int cy, int r, int fill, int hl);
    in_item_t it;
    it.center_x        = COORD_W'(cx);
    it.center_y        = COORD_W'(cy);
    it.radius          = RAD_IN_W'(r);
    it.fill_color      = COLOR_W'(fill);
    it.highlight_color = COLOR_W'(hl);
    return it;
  endfunction

  // mostly discs that overlap the band, the rest anywhere on the plane
  function automatic in_item_t random_disc();
    in_item_t it;
    int r;
    int rows;
    int lo;
    int hi;
    it.center_x        = COORD_W'($urandom);
    it.center_y        = COORD_W'($urandom);
    it.radius          = RAD_IN_W'($urandom);
    it.fill_color      = COLOR_W'($urandom);
    it.highlight_color = COLOR_W'($urandom);
    if ($urandom_range(99) < 75) begin
      r = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(20);
      it.radius = RAD_IN_W'(r);
      if (r < 1) r = 1;
      if (r > MAX_R) r = MAX_R;
      rows = band_cfg.band_row_count;
      if (rows > BAND_LINES) rows = BAND_LINES;
      lo = int'(band_cfg.band_first_row) - r - 2;
      hi = int'(band_cfg.band_first_row) + rows + r + 1;
      if (hi > 2047) hi = 2047;
      it.center_y = COORD_W'(int'($urandom_range(hi - lo)) + lo);
      it.center_x = COORD_W'(int'($urandom_range(LINE_COLS + 40)) - 20);
    end
    return it;
  endfunction

  task automatic send_disc(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_spans(it);
    discs_sent++;
  endtask

  // waits out every expected span plus any zero-span work still in flight
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_item_t c;
    c.index = idx;
    c.wdata = CFG_DATA_W'($urandom);
    case (idx)
      REG_BAND_FIRST_ROW: begin
        c.wdata[FIRST_ROW_W-1:0] = FIRST_ROW_W'(val);
        band_cfg.band_first_row = FIRST_ROW_W'(val);
      end
      REG_BAND_ROW_COUNT: begin
        c.wdata[ROW_CNT_W-1:0] = ROW_CNT_W'(val);
        band_cfg.band_row_count = ROW_CNT_W'(val);
      end
      REG_HIGHLIGHT_ON: begin
        c.wdata[0] = val[0];
        band_cfg.highlight_on = val[0];
      end
      default: begin
      end
    endcase
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= c;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic set_band(input int first_row, input int row_count, input int hl);
    settle();
    write_reg(REG_BAND_FIRST_ROW, first_row);
    write_reg(REG_BAND_ROW_COUNT, row_count);
    write_reg(REG_HIGHLIGHT_ON, hl);
  endtask

  task automatic test_default_band();
    send_disc(make_disc(160, 8, 16, 16'h0000, 16'hFFFF));
    send_disc(make_disc(160, 8, 255, 16'hFFFF, 16'h0000));
    send_disc(make_disc(100, 3, 0, 16'h1234, 16'h5678));
    send_disc(make_disc(50, 5, 1, 16'hA5A5, 16'h5A5A));
    send_disc(make_disc(50, 5, 2, 16'h00FF, 16'hFF00));
    send_disc(make_disc(50, 5, 3, 16'h0F0F, 16'hF0F0));
    send_disc(make_disc(0, 0, 17, 16'h8001, 16'h7FFE));
    send_disc(make_disc(319, 15, 16, 16'h4321, 16'h8765));
    send_disc(make_disc(-2048, -2048, 8, 16'hFFFF, 16'hFFFF));
    send_disc(make_disc(2047, 2047, 8, 16'h0000, 16'h0000));
    send_disc(make_disc(-5, 8, 4, 16'h1111, 16'h2222));
    send_disc(make_disc(330, 8, 12, 16'h3333, 16'h4444));
    send_disc(make_disc(-17, 8, 16, 16'h5555, 16'h6666));
    send_disc(make_disc(160, -17, 16, 16'h7777, 16'h8888));
    send_disc(make_disc(160, 32, 16, 16'h9999, 16'hAAAA));
  endtask

  // last band on screen, row count above the band height, spare index
  task automatic test_band_edges();
    set_band(2047, 31, 1);
    write_reg(REG_SPARE, 16'hFFFF);
    send_disc(make_disc(10, 2047, 16, 16'hBEEF, 16'hCAFE));
    send_disc(make_disc(-2048, 2047, 5, 16'hDEAD, 16'hF00D));
    send_disc(make_disc(300, 2040, 255, 16'h0001, 16'h8000));
    send_disc(make_disc(160, 2032, 16, 16'hFFFE, 16'h7FFF));
  endtask

  task automatic test_zero_rows();
    set_band(500, 0, 1);
    send_disc(make_disc(160, 500, 16, 16'h1357, 16'h2468));
    send_disc(make_disc(20, 505, 3, 16'h9BDF, 16'hACE0));
  endtask

  task automatic test_random_bands();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_band(0, 16, 1);
        1: set_band(2047, 1, 0);
        2: set_band(1000, 1, 1);
        3: set_band($urandom_range(2047), $urandom_range(31), $urandom_range(1));
        4: set_band($urandom_range(40), $urandom_range(1, 16), 1);
        default: set_band($urandom_range(2047), $urandom_range(1, 16), 0);
      endcase
      repeat (60) send_disc(random_disc());
    end
  endtask

  task automatic test_back_to_back();
    set_band(100, 16, 1);
    idle_pct = 0;
    repeat (50) send_disc(random_disc());
    settle();
    idle_pct = IDLE_PCT;
  endtask

  // result side: random back-pressure and in-order compare
  initial begin : span_checker
    out_item_t got;
    out_item_t want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (pending_spans.size() == 0) begin
          $error("unexpected span: row %0d cols %0d..%0d color %h last %b",
                 got.band_row, got.span_start, got.span_end, got.span_color,
                 got.last_span);
          error_count++;
        end else begin
          want = pending_spans.pop_front();
          spans_checked++;
          if (got.band_row !== want.band_row) begin
            $error("band_row: expected %0d, got %0d", want.band_row, got.band_row);
            error_count++;
          end
          if (got.span_start !== want.span_start) begin
            $error("span_start: expected %0d, got %0d", want.span_start, got.span_start);
            error_count++;
          end
          if (got.span_end !== want.span_end) begin
            $error("span_end: expected %0d, got %0d", want.span_end, got.span_end);
            error_count++;
          end
          if (got.span_color !== want.span_color) begin
            $error("span_color: expected %h, got %h", want.span_color, got.span_color);
            error_count++;
          end
          if (got.last_span !== want.last_span) begin
            $error("last_span: expected %b, got %b", want.last_span, got.last_span);
            error_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    @(posedge rst_ni);
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $error("no item moved for %0d cycles, %0d spans outstanding", STALL_LIMIT,
           pending_spans.size());
    $display("band_disc_span_rasterizer_core regression: fail");
    $finish;
  end

  initial begin
    idle_pct      = IDLE_PCT;
    discs_sent    = 0;
    spans_checked = 0;
    reg_writes    = 0;
    error_count   = 0;
    band_cfg.band_first_row = '0;
    band_cfg.band_row_count = ROW_CNT_W'(16);
    band_cfg.highlight_on   = 1'b1;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_band();
    test_band_edges();
    test_zero_rows();
    test_random_bands();
    test_back_to_back();
    settle();

    $display("%0d discs sent over %0d register writes, %0d spans compared",
             discs_sent, reg_writes, spans_checked);
    $display("bands covered: top and bottom of screen, single row, empty and saturated");
    if (error_count == 0) begin
      $display("band_disc_span_rasterizer_core regression: pass");
    end else begin
      $display("band_disc_span_rasterizer_core regression: fail");
    end
    $finish;
  end

endmodule
